FILE: rtl/core/spma_pkg.sv
// ----------------------------------------------------------------------------
// spma_pkg
// Shared sizes, operation and status codes, and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spma_pkg;

    // list depth and derived widths
    localparam int MAX_TERMS = 32;
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    // field widths
    localparam int OP_W   = 2;
    localparam int COEF_W = 16;
    localparam int EXP_W  = 16;
    localparam int SUM_W  = COEF_W + 1;
    localparam int STS_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND_ONE = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_TWO = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD        = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] ST_TERM  = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic             append_one;
        logic             append_two;
        logic             clear;
        logic             start;
        logic             flag;
        logic [STS_W-1:0] flag_status;
        logic             emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic full_one;
        logic full_two;
        logic both_empty;
        logic merge_last;
    } t_sts;

endpackage

FILE: rtl/core/spma_ctrl.sv
// ----------------------------------------------------------------------------
// spma_ctrl
// Controller: decodes each input item and steps the merge one term at a time.
// ----------------------------------------------------------------------------
module spma_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [spma_pkg::OP_W-1:0] i_operation,
    input  spma_pkg::t_sts           i_sts,
    output logic                     o_ready,
    output spma_pkg::t_cmd           o_cmd
);
    import spma_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_MERGE = 1'b1;

    logic r_state;
    logic n_state;
    logic w_fire;

    // idle and the output slot can take a result
    assign o_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign w_fire  = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.flag_status = ST_TERM;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    unique case (i_operation)
                        OP_APPEND_ONE: begin
                            if (i_sts.full_one) begin
                                o_cmd.flag        = 1'b1;
                                o_cmd.flag_status = ST_FULL;
                            end else begin
                                o_cmd.append_one = 1'b1;
                            end
                        end
                        OP_APPEND_TWO: begin
                            if (i_sts.full_two) begin
                                o_cmd.flag        = 1'b1;
                                o_cmd.flag_status = ST_FULL;
                            end else begin
                                o_cmd.append_two = 1'b1;
                            end
                        end
                        OP_ADD: begin
                            if (i_sts.both_empty) begin
                                o_cmd.flag        = 1'b1;
                                o_cmd.flag_status = ST_EMPTY;
                            end else begin
                                o_cmd.start = 1'b1;
                                n_state     = S_MERGE;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MERGE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.merge_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/spma_dp.sv
// ----------------------------------------------------------------------------
// spma_dp
// Datapath: term storage, counts, merge indices, head compare and the
// output register.
// ----------------------------------------------------------------------------
module spma_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spma_pkg::t_cmd                     i_cmd,
    input  logic signed [spma_pkg::COEF_W-1:0] i_coefficient,
    input  logic        [spma_pkg::EXP_W-1:0]  i_exponent,
    input  logic                               i_out_ready,
    output spma_pkg::t_sts                     o_sts,
    output logic                               o_valid,
    output logic        [spma_pkg::STS_W-1:0]  o_status,
    output logic signed [spma_pkg::SUM_W-1:0]  o_sum_coefficient,
    output logic        [spma_pkg::EXP_W-1:0]  o_sum_exponent,
    output logic                               o_last
);
    import spma_pkg::*;

    logic [COEF_W-1:0] r_coef_one [MAX_TERMS];
    logic [EXP_W-1:0]  r_exp_one  [MAX_TERMS];
    logic [COEF_W-1:0] r_coef_two [MAX_TERMS];
    logic [EXP_W-1:0]  r_exp_two  [MAX_TERMS];

    logic [CNT_W-1:0] r_cnt_one;
    logic [CNT_W-1:0] r_cnt_two;
    logic [CNT_W-1:0] r_idx_one;
    logic [CNT_W-1:0] r_idx_two;
    logic [CNT_W-1:0] n_idx_one;
    logic [CNT_W-1:0] n_idx_two;

    logic                    r_valid;
    logic [STS_W-1:0]        r_status;
    logic signed [SUM_W-1:0] r_coef;
    logic [EXP_W-1:0]        r_exp;
    logic                    r_last;

    logic [COEF_W-1:0]       w_c1;
    logic [COEF_W-1:0]       w_c2;
    logic [EXP_W-1:0]        w_e1;
    logic [EXP_W-1:0]        w_e2;
    logic                    w_have_one;
    logic                    w_have_two;
    logic                    w_take_one;
    logic                    w_take_two;
    logic signed [SUM_W-1:0] w_sum;
    logic [EXP_W-1:0]        w_exp;

    // term storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_one) begin
            r_coef_one[r_cnt_one[IDX_W-1:0]] <= i_coefficient;
            r_exp_one[r_cnt_one[IDX_W-1:0]]  <= i_exponent;
        end
        if (i_cmd.append_two) begin
            r_coef_two[r_cnt_two[IDX_W-1:0]] <= i_coefficient;
            r_exp_two[r_cnt_two[IDX_W-1:0]]  <= i_exponent;
        end
    end

    // list heads
    assign w_c1 = r_coef_one[r_idx_one[IDX_W-1:0]];
    assign w_e1 = r_exp_one[r_idx_one[IDX_W-1:0]];
    assign w_c2 = r_coef_two[r_idx_two[IDX_W-1:0]];
    assign w_e2 = r_exp_two[r_idx_two[IDX_W-1:0]];

    // head compare: larger exponent first, ties take both
    assign w_have_one = r_idx_one < r_cnt_one;
    assign w_have_two = r_idx_two < r_cnt_two;
    assign w_take_one = w_have_one && (!w_have_two || (w_e1 >= w_e2));
    assign w_take_two = w_have_two && (!w_have_one || (w_e2 >= w_e1));

    assign w_sum = (w_take_one ? $signed({w_c1[COEF_W-1], w_c1}) : SUM_W'(0))
                 + (w_take_two ? $signed({w_c2[COEF_W-1], w_c2}) : SUM_W'(0));
    assign w_exp = w_take_one ? w_e1 : w_e2;

    assign n_idx_one = r_idx_one + CNT_W'(w_take_one);
    assign n_idx_two = r_idx_two + CNT_W'(w_take_two);

    // status to the controller
    assign o_sts.out_free   = !r_valid || i_out_ready;
    assign o_sts.full_one   = r_cnt_one == CNT_W'(MAX_TERMS);
    assign o_sts.full_two   = r_cnt_two == CNT_W'(MAX_TERMS);
    assign o_sts.both_empty = (r_cnt_one == '0) && (r_cnt_two == '0);
    assign o_sts.merge_last = (n_idx_one >= r_cnt_one) && (n_idx_two >= r_cnt_two);

    // counts and merge indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_one <= '0;
            r_cnt_two <= '0;
            r_idx_one <= '0;
            r_idx_two <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt_one <= '0;
                r_cnt_two <= '0;
            end
            if (i_cmd.append_one) begin
                r_cnt_one <= r_cnt_one + CNT_W'(1);
            end
            if (i_cmd.append_two) begin
                r_cnt_two <= r_cnt_two + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_idx_one <= '0;
                r_idx_two <= '0;
            end else if (i_cmd.emit) begin
                r_idx_one <= n_idx_one;
                r_idx_two <= n_idx_two;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.flag || i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.flag) begin
            r_status <= i_cmd.flag_status;
            r_coef   <= '0;
            r_exp    <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_status <= ST_TERM;
            r_coef   <= w_sum;
            r_exp    <= w_exp;
            r_last   <= o_sts.merge_last;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_sum_coefficient = r_coef;
    assign o_sum_exponent    = r_exp;
    assign o_last            = r_last;

endmodule

FILE: rtl/core/sparse_polynomial_merge_add.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add
// Two term lists with append, clear and a merge-add that streams the sum.
// ----------------------------------------------------------------------------
// Append and clear items are applied as they are taken; a dropped append or an
// empty add gives its result in the cycle after the item is taken.
// An add emits one merged term per cycle while i_ready holds; the start item
// moves the controller into its merge state, which then loads each term into
// the output register. There are n1 + n2 minus ties output terms, and the rate
// is set by the single head compare and index step of the merge loop.
// No new item is taken during a merge. Reset clears counts, indices, state
// and output valid; term storage is not cleared and needs no clearing pass.
module sparse_polynomial_merge_add (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic        [spma_pkg::OP_W-1:0]   i_operation,
    input  logic signed [spma_pkg::COEF_W-1:0] i_coefficient,
    input  logic        [spma_pkg::EXP_W-1:0]  i_exponent,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic        [spma_pkg::STS_W-1:0]  o_status,
    output logic signed [spma_pkg::SUM_W-1:0]  o_sum_coefficient,
    output logic        [spma_pkg::EXP_W-1:0]  o_sum_exponent,
    output logic                               o_last
);
    import spma_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // controller
    spma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_ready     (o_ready),
        .o_cmd       (w_cmd)
    );

    // datapath
    spma_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_coefficient     (i_coefficient),
        .i_exponent        (i_exponent),
        .i_out_ready       (i_ready),
        .o_sts             (w_sts),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_sum_coefficient (o_sum_coefficient),
        .o_sum_exponent    (o_sum_exponent),
        .o_last            (o_last)
    );

    // a term is only loaded into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("merge term loaded over a waiting item");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.append_one, w_cmd.append_two, w_cmd.clear,
                  w_cmd.start, w_cmd.flag, w_cmd.emit}))
        else $error("conflicting datapath commands");

    // the final merge term carries the last marker
    a_last_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_sts.merge_last) |=> (o_valid && o_last))
        else $error("final merge term without last marker");

    // a flagged result is a single item with last set and zero payload
    a_flag_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flag |=> (o_valid && o_last && (o_sum_exponent == '0)))
        else $error("flagged result malformed");

endmodule
